[src/mtgo_pkg.sv]
// Shared types and constants for the monochrome tile to grayscale OLED byte stream block.
package mtgo_pkg;

  // Controller command bytes.
  localparam logic [7:0] CMD_ROW_ADDR = 8'h75;
  localparam logic [7:0] CMD_COL_ADDR = 8'h15;
  localparam logic [7:0] CMD_WRITE_RAM = 8'h5C;

  // Nibble patterns for a set pixel.
  localparam logic [7:0] NIB_LO_ON = 8'h0F;
  localparam logic [7:0] NIB_HI_ON = 8'hF0;

  // Byte kind codes on the result port.
  localparam logic [1:0] KIND_CMD = 2'd0;
  localparam logic [1:0] KIND_ARG = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  // Reset value of the column offset register.
  localparam logic [7:0] COL_OFFSET_RESET = 8'd8;

  // Byte positions within one tile transaction.
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] STEP_ROW_CMD = 6'd0;
  localparam logic [STEP_W-1:0] STEP_ROW_LO = 6'd1;
  localparam logic [STEP_W-1:0] STEP_ROW_HI = 6'd2;
  localparam logic [STEP_W-1:0] STEP_COL_CMD = 6'd3;
  localparam logic [STEP_W-1:0] STEP_COL_LO = 6'd4;
  localparam logic [STEP_W-1:0] STEP_COL_HI = 6'd5;
  localparam logic [STEP_W-1:0] STEP_WRITE_CMD = 6'd6;
  localparam logic [STEP_W-1:0] STEP_PIX_FIRST = 6'd7;
  localparam logic [STEP_W-1:0] STEP_LAST = 6'd38;

  // Depth of the queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // One classified tile, ready for serialization.
  typedef struct packed {
    logic            first;
    logic [7:0]      row_lo;
    logic [7:0]      row_hi;
    logic [7:0]      col_lo;
    logic [7:0]      col_hi;
    logic [7:0][7:0] pix;
  } tile_desc_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

[src/mtgo_front.sv]
// Front part: holds the column offset and turns an accepted tile into a descriptor.
module mtgo_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                column_offset_we,
  input  logic [7:0]          column_offset_wdata,
  input  logic                start,
  input  logic [5:0]          tile_col,
  input  logic [4:0]          tile_row,
  input  logic                first_in_call,
  input  logic [7:0][7:0]     pix_cols,
  input  mtgo_pkg::q_stat_t   q_stat,
  output logic                busy,
  output logic                push,
  output mtgo_pkg::tile_desc_t desc
);
  import mtgo_pkg::*;

  logic [7:0] column_offset;
  logic [7:0] x_addr;
  logic [7:0] y_addr;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_offset <= COL_OFFSET_RESET;
    end else if (column_offset_we) begin
      column_offset <= column_offset_wdata;
    end
  end

  // Address arithmetic, all modulo 256.
  assign x_addr = {1'b0, tile_col, 1'b0} + column_offset;
  assign y_addr = {tile_row, 3'b000};

  always_comb begin
    desc.first  = first_in_call;
    desc.row_lo = y_addr;
    desc.row_hi = y_addr + 8'd7;
    desc.col_lo = x_addr;
    desc.col_hi = x_addr + 8'd1;
    desc.pix    = pix_cols;
  end

  // A tile is taken whenever the queue has room.
  assign busy = q_stat.full;
  assign push = start && !q_stat.full;

endmodule

[src/mtgo_queue.sv]
// Short queue of tile descriptors between the front and back parts.
module mtgo_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  mtgo_pkg::tile_desc_t din,
  input  logic                 pop,
  output mtgo_pkg::tile_desc_t dout,
  output mtgo_pkg::q_stat_t    stat
);
  import mtgo_pkg::*;

  tile_desc_t        entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  // Pointer and occupancy control.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= din;
    end
  end

  assign dout       = entries[rd_ptr];
  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);

endmodule

[src/mtgo_back.sv]
// Back part: serializes one tile descriptor into command, argument and pixel bytes.
module mtgo_back (
  input  logic                 clk,
  input  logic                 rst,
  input  mtgo_pkg::q_stat_t    q_stat,
  input  mtgo_pkg::tile_desc_t q_data,
  output logic                 pop,
  output logic                 result_strobe,
  output logic [7:0]           out_byte,
  output logic [1:0]           byte_kind,
  output logic                 last_of_tile
);
  import mtgo_pkg::*;

  tile_desc_t        cur;
  logic              active;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] pix_idx;
  logic [2:0]        row_sel;
  logic [1:0]        pair_sel;
  logic [7:0]        lo_col;
  logic [7:0]        hi_col;
  logic [7:0]        byte_next;
  logic [1:0]        kind_next;
  logic              at_last;

  // Pixel byte selection: rows top first, column pairs (2,3) (0,1) (6,7) (4,5).
  assign pix_idx  = step - STEP_PIX_FIRST;
  assign row_sel  = pix_idx[4:2];
  assign pair_sel = {pix_idx[1], ~pix_idx[0]};
  assign lo_col   = cur.pix[{pair_sel, 1'b0}];
  assign hi_col   = cur.pix[{pair_sel, 1'b1}];
  assign at_last  = (step == STEP_LAST);

  // Byte for the current step.
  always_comb begin
    case (step)
      STEP_ROW_CMD: begin
        byte_next = CMD_ROW_ADDR;
        kind_next = KIND_CMD;
      end
      STEP_ROW_LO: begin
        byte_next = cur.row_lo;
        kind_next = KIND_ARG;
      end
      STEP_ROW_HI: begin
        byte_next = cur.row_hi;
        kind_next = KIND_ARG;
      end
      STEP_COL_CMD: begin
        byte_next = CMD_COL_ADDR;
        kind_next = KIND_CMD;
      end
      STEP_COL_LO: begin
        byte_next = cur.col_lo;
        kind_next = KIND_ARG;
      end
      STEP_COL_HI: begin
        byte_next = cur.col_hi;
        kind_next = KIND_ARG;
      end
      STEP_WRITE_CMD: begin
        byte_next = CMD_WRITE_RAM;
        kind_next = KIND_CMD;
      end
      default: begin
        byte_next = (lo_col[row_sel] ? NIB_LO_ON : 8'h00)
                  | (hi_col[row_sel] ? NIB_HI_ON : 8'h00);
        kind_next = KIND_DATA;
      end
    endcase
  end

  // Take the next tile when idle or on the final byte of the current one.
  assign pop = !q_stat.empty && (!active || at_last);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= 1'b0;
      result_strobe <= 1'b0;
      step          <= STEP_ROW_CMD;
    end else begin
      result_strobe <= active;
      if (pop) begin
        active <= 1'b1;
        step   <= q_data.first ? STEP_ROW_CMD : STEP_COL_CMD;
      end else if (active && at_last) begin
        active <= 1'b0;
      end else if (active) begin
        step <= step + 1'b1;
      end
    end
  end

  // Working descriptor.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
  end

  // Registered result bytes.
  always_ff @(posedge clk) begin
    out_byte     <= byte_next;
    byte_kind    <= kind_next;
    last_of_tile <= at_last;
  end

endmodule

[src/mono_tile_to_gray_oled_stream_core.sv]
// Top level of the monochrome tile to grayscale OLED byte stream block.
// Each accepted tile produces 39 bytes when first_in_call is set and 36 otherwise, one byte
// per clock on the result ports, so the byte output sets the tile rate, and tiles run back
// to back when the next one is already queued. A tile is accepted when start is high and
// busy is low; a two-entry queue sits behind the input, so up to two tiles can wait while
// a third is being sent, and busy rises only when that queue is full. A tile's first byte
// passes the queue entry, the back part's step and descriptor registers and the result
// registers. Each byte is shown for exactly one cycle with result_strobe high; the receiver
// cannot hold results off and must take every byte. Write column_offset only while idle.
module mono_tile_to_gray_oled_stream_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       column_offset_we,
  input  logic [7:0] column_offset_wdata,
  input  logic       start,
  output logic       busy,
  input  logic [5:0] tile_col,
  input  logic [4:0] tile_row,
  input  logic       first_in_call,
  input  logic [7:0] column0_bits,
  input  logic [7:0] column1_bits,
  input  logic [7:0] column2_bits,
  input  logic [7:0] column3_bits,
  input  logic [7:0] column4_bits,
  input  logic [7:0] column5_bits,
  input  logic [7:0] column6_bits,
  input  logic [7:0] column7_bits,
  output logic       result_strobe,
  output logic [7:0] out_byte,
  output logic [1:0] byte_kind,
  output logic       last_of_tile
);
  import mtgo_pkg::*;

  logic [7:0][7:0] pix_cols;
  tile_desc_t      desc;
  tile_desc_t      q_data;
  q_stat_t         q_stat;
  logic            push;
  logic            pop;

  // Gather the column bytes, column 0 at index 0.
  assign pix_cols = {column7_bits, column6_bits, column5_bits, column4_bits,
                     column3_bits, column2_bits, column1_bits, column0_bits};

  mtgo_front u_front (
    .clk                 (clk),
    .rst                 (rst),
    .column_offset_we    (column_offset_we),
    .column_offset_wdata (column_offset_wdata),
    .start               (start),
    .tile_col            (tile_col),
    .tile_row            (tile_row),
    .first_in_call       (first_in_call),
    .pix_cols            (pix_cols),
    .q_stat              (q_stat),
    .busy                (busy),
    .push                (push),
    .desc                (desc)
  );

  mtgo_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (desc),
    .pop  (pop),
    .dout (q_data),
    .stat (q_stat)
  );

  mtgo_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_stat        (q_stat),
    .q_data        (q_data),
    .pop           (pop),
    .result_strobe (result_strobe),
    .out_byte      (out_byte),
    .byte_kind     (byte_kind),
    .last_of_tile  (last_of_tile)
  );

endmodule

[src/mtgo_checker.sv]
// Port-level checks for the tile byte stream block, bound to its top level.
module mtgo_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_strobe,
  input logic [7:0] out_byte,
  input logic [1:0] byte_kind,
  input logic       last_of_tile
);
  import mtgo_pkg::*;

  // The end-of-tile mark falls only on a pixel byte.
  a_last_is_data: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && last_of_tile) |-> (byte_kind == KIND_DATA))
    else $error("last_of_tile on a non-pixel byte");

  // Command bytes are only the three known commands.
  a_cmd_code: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && byte_kind == KIND_CMD) |->
      (out_byte == CMD_ROW_ADDR || out_byte == CMD_COL_ADDR || out_byte == CMD_WRITE_RAM))
    else $error("unknown command byte");

  // An address command is followed at once by its argument.
  a_addr_arg: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && byte_kind == KIND_CMD &&
     (out_byte == CMD_ROW_ADDR || out_byte == CMD_COL_ADDR)) |=>
      (result_strobe && byte_kind == KIND_ARG))
    else $error("address command not followed by an argument");

  // The write command is followed at once by pixel data.
  a_write_data: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && byte_kind == KIND_CMD && out_byte == CMD_WRITE_RAM) |=>
      (result_strobe && byte_kind == KIND_DATA))
    else $error("write command not followed by pixel data");

endmodule

bind mono_tile_to_gray_oled_stream_core mtgo_checker u_mtgo_checker (
  .clk           (clk),
  .rst           (rst),
  .result_strobe (result_strobe),
  .out_byte      (out_byte),
  .byte_kind     (byte_kind),
  .last_of_tile  (last_of_tile)
);

[test/tb_mono_tile_to_gray_oled_stream_core.sv]
// Self-checking testbench for the monochrome tile to grayscale OLED byte stream block.
`timescale 1ns / 1ps

module tb_mono_tile_to_gray_oled_stream_core;
  import mtgo_pkg::*;

  // One 8x8 tile as the driver presents it.
  typedef struct {
    bit [5:0]      col;
    bit [4:0]      row;
    bit            first;
    bit [7:0][7:0] pix;
  } tile_t;

  // One byte as the block should emit it.
  typedef struct {
    bit [7:0] value;
    bit [1:0] kind;
    bit       last;
  } oled_byte_t;

  // Works out the byte stream of each accepted tile and checks the emitted bytes in order.
  class gray_stream_board;
    bit [7:0]   col_offset;
    oled_byte_t queued_bytes[$];
    int         mismatches;
    int         tiles_seen;
    int         bytes_seen;

    function new();
      col_offset = COL_OFFSET_RESET;
    endfunction

    function void push_byte(bit [7:0] value, bit [1:0] kind, bit last);
      oled_byte_t b;
      b.value = value;
      b.kind = kind;
      b.last = last;
      queued_bytes.push_back(b);
    endfunction

    // Nibble pair for pixel row i: lo column fills bits 3:0, hi column bits 7:4.
    function bit [7:0] pair_nibbles(bit [7:0] lo_col, bit [7:0] hi_col, int i);
      return (lo_col[i] ? NIB_LO_ON : 8'h00) | (hi_col[i] ? NIB_HI_ON : 8'h00);
    endfunction

    // Note an accepted tile transaction and queue the bytes it must produce.
    function void note_tile(tile_t t);
      bit [7:0] y;
      bit [7:0] x;
      tiles_seen++;
      if (t.first) begin
        y = {t.row, 3'b000};
        push_byte(CMD_ROW_ADDR, KIND_CMD, 1'b0);
        push_byte(y, KIND_ARG, 1'b0);
        push_byte(y + 8'd7, KIND_ARG, 1'b0);
      end
      x = {1'b0, t.col, 1'b0} + col_offset;
      push_byte(CMD_COL_ADDR, KIND_CMD, 1'b0);
      push_byte(x, KIND_ARG, 1'b0);
      push_byte(x + 8'd1, KIND_ARG, 1'b0);
      push_byte(CMD_WRITE_RAM, KIND_CMD, 1'b0);
      // Column pairs go out in the order (2,3), (0,1), (6,7), (4,5) for each pixel row.
      for (int i = 0; i < 8; i++) begin
        push_byte(pair_nibbles(t.pix[2], t.pix[3], i), KIND_DATA, 1'b0);
        push_byte(pair_nibbles(t.pix[0], t.pix[1], i), KIND_DATA, 1'b0);
        push_byte(pair_nibbles(t.pix[6], t.pix[7], i), KIND_DATA, 1'b0);
        push_byte(pair_nibbles(t.pix[4], t.pix[5], i), KIND_DATA, i == 7);
      end
    endfunction

    // Compare one emitted byte with the oldest queued byte, field by field.
    function void check_byte(logic [7:0] value, logic [1:0] kind, logic last);
      oled_byte_t e;
      bytes_seen++;
      if (queued_bytes.size() == 0) begin
        $display("%0t: unexpected byte %h kind %0d last %b", $time, value, kind, last);
        mismatches++;
        return;
      end
      e = queued_bytes.pop_front();
      if (value !== e.value) begin
        $display("%0t: out_byte expected %h actual %h", $time, e.value, value);
        mismatches++;
      end
      if (kind !== e.kind) begin
        $display("%0t: byte_kind expected %0d actual %0d", $time, e.kind, kind);
        mismatches++;
      end
      if (last !== e.last) begin
        $display("%0t: last_of_tile expected %b actual %b", $time, e.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return queued_bytes.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       column_offset_we;
  logic [7:0] column_offset_wdata;
  logic       start;
  logic       busy;
  logic [5:0] tile_col;
  logic [4:0] tile_row;
  logic       first_in_call;
  logic [7:0] column_bits [8];
  logic       result_strobe;
  logic [7:0] out_byte;
  logic [1:0] byte_kind;
  logic       last_of_tile;

  gray_stream_board board = new();
  int offsets_written;

  mono_tile_to_gray_oled_stream_core dut (
    .clk                 (clk),
    .rst                 (rst),
    .column_offset_we    (column_offset_we),
    .column_offset_wdata (column_offset_wdata),
    .start               (start),
    .busy                (busy),
    .tile_col            (tile_col),
    .tile_row            (tile_row),
    .first_in_call       (first_in_call),
    .column0_bits        (column_bits[0]),
    .column1_bits        (column_bits[1]),
    .column2_bits        (column_bits[2]),
    .column3_bits        (column_bits[3]),
    .column4_bits        (column_bits[4]),
    .column5_bits        (column_bits[5]),
    .column6_bits        (column_bits[6]),
    .column7_bits        (column_bits[7]),
    .result_strobe       (result_strobe),
    .out_byte            (out_byte),
    .byte_kind           (byte_kind),
    .last_of_tile        (last_of_tile)
  );

  // Clock with a 4 ns period.
  always #2 clk = ~clk;

  // Every strobed byte is taken at the rising edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && result_strobe) begin
      board.check_byte(out_byte, byte_kind, last_of_tile);
    end
  end

  // Mostly back-to-back tiles, some short gaps and a few long ones.
  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  function tile_t random_tile();
    tile_t t;
    int r;
    t.col = 6'($urandom_range(0, 63));
    t.row = 5'($urandom_range(0, 31));
    t.first = ($urandom_range(0, 2) == 0);
    for (int c = 0; c < 8; c++) begin
      r = $urandom_range(0, 9);
      t.pix[c] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom());
    end
    return t;
  endfunction

  function tile_t make_tile(bit [5:0] col, bit [4:0] row, bit first, bit [63:0] pix);
    tile_t t;
    t.col = col;
    t.row = row;
    t.first = first;
    t.pix = pix;
    return t;
  endfunction

  // Present one tile, wait until it is accepted, then hold start low for the requested gap.
  task automatic send_tile(tile_t t, int gap);
    @(negedge clk);
    start <= 1'b1;
    tile_col <= t.col;
    tile_row <= t.row;
    first_in_call <= t.first;
    for (int c = 0; c < 8; c++) column_bits[c] <= t.pix[c];
    do @(posedge clk); while (busy);
    board.note_tile(t);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drain all queued bytes, then let the pipeline settle before touching the register.
  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (board.pending() > 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_offset(bit [7:0] value);
    wait_idle();
    @(negedge clk);
    column_offset_we <= 1'b1;
    column_offset_wdata <= value;
    @(posedge clk);
    board.col_offset = value;
    offsets_written++;
    @(negedge clk);
    column_offset_we <= 1'b0;
  endtask

  task automatic random_phase(int count, bit no_gaps);
    for (int n = 0; n < count; n++) begin
      send_tile(random_tile(), no_gaps ? 0 : pick_gap());
    end
  endtask

  // Main sequence.
  initial begin
    rst = 1'b1;
    column_offset_we = 1'b0;
    column_offset_wdata = 8'h00;
    start = 1'b0;
    tile_col = '0;
    tile_row = '0;
    first_in_call = 1'b0;
    for (int c = 0; c < 8; c++) column_bits[c] = 8'h00;
    offsets_written = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed tiles under the reset offset: field extremes and pixel patterns.
    send_tile(make_tile(6'd0, 5'd0, 1'b1, 64'h0), pick_gap());
    send_tile(make_tile(6'd63, 5'd31, 1'b1, {8{8'hFF}}), pick_gap());
    send_tile(make_tile(6'd63, 5'd31, 1'b0, 64'h8040201008040201), 0);
    send_tile(make_tile(6'd17, 5'd9, 1'b0, {4{16'hAA55}}), 0);
    send_tile(make_tile(6'd5, 5'd22, 1'b1, 64'h00000000000000FF), pick_gap());
    send_tile(make_tile(6'd40, 5'd1, 1'b0, 64'hFF00000000000000), pick_gap());
    send_tile(make_tile(6'd21, 5'd16, 1'b0, 64'h0000FF0000FF0000), 0);
    send_tile(make_tile(6'd42, 5'd15, 1'b1, 64'h0102040810204080), pick_gap());

    // Zero offset, random tiles.
    write_offset(8'h00);
    send_tile(make_tile(6'd63, 5'd31, 1'b1, {8{8'h81}}), pick_gap());
    random_phase(100, 1'b0);

    // Largest offset: column addresses wrap past 255.
    write_offset(8'hFF);
    send_tile(make_tile(6'd0, 5'd0, 1'b1, {8{8'hF0}}), pick_gap());
    send_tile(make_tile(6'd63, 5'd7, 1'b0, {8{8'h0F}}), pick_gap());
    send_tile(make_tile(6'd1, 5'd31, 1'b1, 64'hFFFFFFFF00000000), pick_gap());
    random_phase(100, 1'b0);

    // Random offset with tiles back to back so the input queue fills.
    write_offset(8'($urandom()));
    random_phase(120, 1'b1);

    // Offset just below the top, random tiles with gaps.
    write_offset(8'hFE);
    send_tile(make_tile(6'd0, 5'd0, 1'b0, 64'h0), pick_gap());
    random_phase(100, 1'b0);

    wait_idle();
    $display("Covered %0d tiles and %0d bytes across %0d column offset settings.",
             board.tiles_seen, board.bytes_seen, offsets_written + 1);
    if (board.mismatches == 0) begin
      $display("mono_tile_to_gray_oled_stream_core verification clean");
    end else begin
      $display("mono_tile_to_gray_oled_stream_core verification failed");
    end
    $finish;
  end

  // Safety limit well above the slowest correct run.
  initial begin
    #2000000;
    $display("mono_tile_to_gray_oled_stream_core verification failed");
    $finish;
  end

endmodule
